>>> rtl/core/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// property holds in every cycle out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/core/etok_pkg.sv
// types, codes and character classes for the expression tokenizer
// no dependencies; used by etok_decode and expression_tokenizer_core
package etok_pkg;

    localparam int MAX_RES = 5;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_END_TOKEN = 2'd1,
        KIND_END_EXPR  = 2'd2
    } kind_t;

    typedef enum logic [8:0] {
        MS_IDLE = 9'b000000001,
        MS_S    = 9'b000000010,
        MS_SI   = 9'b000000100,
        MS_C    = 9'b000001000,
        MS_CO   = 9'b000010000,
        MS_T    = 9'b000100000,
        MS_TA   = 9'b001000000,
        MS_L    = 9'b010000000,
        MS_LN   = 9'b100000000
    } match_t;

    typedef struct packed {
        match_t ms;
        logic   num_open;
    } etok_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
    } etok_res_t;

    typedef struct packed {
        etok_res_t [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]        cnt;
    } etok_bundle_t;

    function automatic etok_bundle_t etok_push(input etok_bundle_t b, input kind_t k,
                                               input logic [7:0] c);
        etok_bundle_t r;
        r = b;
        r.ent[b.cnt[IDX_W-1:0]].kind = k;
        r.ent[b.cnt[IDX_W-1:0]].chr  = (k == KIND_CHAR) ? c : 8'd0;
        r.cnt = b.cnt + CNT_W'(1);
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c == ".");
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "^") || (c == "%") || (c == "(") || (c == ")");
    endfunction

endpackage

>>> rtl/core/etok_decode.sv
// combinational decode of one transaction into its result bundle and next state
// depends on etok_pkg
module etok_decode import etok_pkg::*; (
    input  logic         req_type,
    input  logic [7:0]   ch,
    input  etok_state_t  state,
    output etok_bundle_t bundle,
    output etok_state_t  state_next
);

    etok_bundle_t b;
    etok_state_t  sn;
    logic         fresh;
    logic         name;
    logic [7:0]   n0;
    logic [7:0]   n1;

    always_comb begin
        b     = '0;
        sn    = state;
        fresh = 1'b0;
        name  = 1'b0;
        n0    = 8'd0;
        n1    = 8'd0;
        if (req_type) begin
            if (state.ms == MS_LN) begin
                b = etok_push(b, KIND_END_TOKEN, 8'd0);
            end
            sn.ms = MS_IDLE;
            if (state.num_open) begin
                b = etok_push(b, KIND_END_TOKEN, 8'd0);
            end
            sn.num_open = 1'b0;
            b = etok_push(b, KIND_END_EXPR, 8'd0);
        end else begin
            unique case (state.ms)
                MS_S: begin
                    if (ch == "i") sn.ms = MS_SI;
                    else fresh = 1'b1;
                end
                MS_SI: begin
                    if (ch == "n") begin
                        name = 1'b1; n0 = "s"; n1 = "i";
                    end else fresh = 1'b1;
                end
                MS_C: begin
                    if (ch == "o") sn.ms = MS_CO;
                    else fresh = 1'b1;
                end
                MS_CO: begin
                    if (ch == "s") begin
                        name = 1'b1; n0 = "c"; n1 = "o";
                    end else fresh = 1'b1;
                end
                MS_T: begin
                    if (ch == "a") sn.ms = MS_TA;
                    else fresh = 1'b1;
                end
                MS_TA: begin
                    if (ch == "n") begin
                        name = 1'b1; n0 = "t"; n1 = "a";
                    end else fresh = 1'b1;
                end
                MS_L: begin
                    if (ch == "n") begin
                        if (state.num_open) begin
                            b = etok_push(b, KIND_END_TOKEN, 8'd0);
                        end
                        sn.num_open = 1'b0;
                        b = etok_push(b, KIND_CHAR, "l");
                        b = etok_push(b, KIND_CHAR, "n");
                        sn.ms = MS_LN;
                    end else fresh = 1'b1;
                end
                MS_LN: begin
                    if (is_alpha(ch)) begin
                        b = etok_push(b, KIND_CHAR, ch);
                        b = etok_push(b, KIND_END_TOKEN, 8'd0);
                        sn.ms = MS_IDLE;
                    end else begin
                        b = etok_push(b, KIND_END_TOKEN, 8'd0);
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase

            if (name) begin
                if (state.num_open) begin
                    b = etok_push(b, KIND_END_TOKEN, 8'd0);
                end
                sn.num_open = 1'b0;
                b = etok_push(b, KIND_CHAR, n0);
                b = etok_push(b, KIND_CHAR, n1);
                b = etok_push(b, KIND_CHAR, ch);
                b = etok_push(b, KIND_END_TOKEN, 8'd0);
                sn.ms = MS_IDLE;
            end

            if (fresh) begin
                sn.ms = MS_IDLE;
                priority if (is_space(ch)) begin
                    sn.ms = MS_IDLE;
                end else if (is_num(ch)) begin
                    b = etok_push(b, KIND_CHAR, ch);
                    sn.num_open = 1'b1;
                end else if (is_op(ch)) begin
                    if (sn.num_open) begin
                        b = etok_push(b, KIND_END_TOKEN, 8'd0);
                    end
                    sn.num_open = 1'b0;
                    b = etok_push(b, KIND_CHAR, ch);
                    b = etok_push(b, KIND_END_TOKEN, 8'd0);
                end else if (ch == "s") begin
                    sn.ms = MS_S;
                end else if (ch == "c") begin
                    sn.ms = MS_C;
                end else if (ch == "t") begin
                    sn.ms = MS_T;
                end else if (ch == "l") begin
                    sn.ms = MS_L;
                end else begin
                    sn.ms = MS_IDLE;
                end
            end
        end
    end

    assign bundle     = b;
    assign state_next = sn;

endmodule

>>> rtl/core/expression_tokenizer_core.sv
// top level of the streaming calculator tokenizer
// depends on etok_pkg, etok_decode and assert_macros.svh
//
//  channel | ports                                   | direction
//  s_      | s_valid s_ready s_req_type s_ch         | in, one character or end mark
//  m_      | m_valid m_ready m_out_kind m_out_char   | out, token chars and marks
//          | m_run_last                              |
//
// a transaction enters an input register, is decoded combinationally and its 0..5
// results land in an output bundle register that drains one result per cycle while
// m_ready is high. the first result is valid once the input register has passed its
// transaction to the free output register. a transaction holds the output register
// until all its results are taken; one with no results leaves the output free.
// aresetn clears the match state, the open-number flag and all valid flags.
// s_ready falls while a held transaction waits for the output register to free up.
`include "assert_macros.svh"

module expression_tokenizer_core import etok_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_char,
    output logic       m_run_last
);

    logic         in_valid_reg;
    logic         in_req_reg;
    logic [7:0]   in_ch_reg;
    etok_state_t  state_reg;
    etok_state_t  state_next;
    etok_bundle_t out_bundle_reg;
    etok_bundle_t dec_bundle;
    logic [IDX_W-1:0] out_idx_reg;
    logic         out_valid_reg;
    logic         out_last;
    logic         out_done;
    logic         out_free;
    logic         advance;
    etok_res_t    cur;

    etok_decode u_decode (
        .req_type  (in_req_reg),
        .ch        (in_ch_reg),
        .state     (state_reg),
        .bundle    (dec_bundle),
        .state_next(state_next)
    );

    assign cur      = out_bundle_reg.ent[out_idx_reg];
    assign out_last = (CNT_W'(out_idx_reg) + CNT_W'(1)) == out_bundle_reg.cnt;
    assign out_done = out_valid_reg && m_ready && out_last;
    assign out_free = !out_valid_reg || out_done;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    assign m_valid    = out_valid_reg;
    assign m_out_kind = cur.kind;
    assign m_out_char = cur.chr;
    assign m_run_last = out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_idx_reg    <= '0;
            state_reg.ms       <= MS_IDLE;
            state_reg.num_open <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= (dec_bundle.cnt != '0);
                out_idx_reg   <= '0;
            end else if (out_done) begin
                out_valid_reg <= 1'b0;
            end else if (out_valid_reg && m_ready) begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_req_type;
            in_ch_reg  <= s_ch;
        end
        if (advance) begin
            out_bundle_reg <= dec_bundle;
        end
    end

    `ASSERT_ALWAYS(a_idx_in_range, aclk, aresetn,
        !out_valid_reg || (CNT_W'(out_idx_reg) < out_bundle_reg.cnt))
    `ASSERT_ALWAYS(a_ln_closes_number, aclk, aresetn,
        !(state_reg.num_open && state_reg.ms == MS_LN))
    `ASSERT_NEXT(a_idx_steps, aclk, aresetn, m_valid && m_ready && !m_run_last,
        m_valid && (out_idx_reg == $past(out_idx_reg) + IDX_W'(1)))
    `ASSERT_IMPL(a_end_expr_last, aclk, aresetn,
        m_valid && (m_out_kind == KIND_END_EXPR), m_run_last)

endmodule

>>> tb/expression_tokenizer_checker.sv
// scoreboard for the expression tokenizer: watches both channels, predicts the
// token stream of every accepted character and compares each result transaction
// depends on etok_pkg for the result kind and name-match state types
module expression_tokenizer_checker import etok_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_ch,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_out_kind,
    input  logic [7:0] m_out_char,
    input  logic       m_run_last,
    output int         err_count,
    output int         n_pending,
    output int         n_inputs,
    output int         n_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_END = 1'b1;

    typedef struct {
        kind_t      kind;
        logic [7:0] chr;
        logic       last;
    } token_out_t;

    token_out_t token_q[$];
    token_out_t step_q[$];
    token_out_t want;
    match_t     name_state = MS_IDLE;
    logic       number_open = 1'b0;

    initial begin
        err_count = 0;
        n_pending = 0;
        n_inputs  = 0;
        n_results = 0;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic number_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c == ".");
    endfunction

    function automatic logic operator_char(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "^") || (c == "%") || (c == "(") || (c == ")");
    endfunction

    task automatic add_result(input kind_t k, input logic [7:0] c);
        token_out_t r;
        r.kind = k;
        r.chr  = (k == KIND_CHAR) ? c : 8'd0;
        r.last = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic close_number();
        if (number_open) begin
            add_result(KIND_END_TOKEN, 8'd0);
            number_open = 1'b0;
        end
    endtask

    task automatic start_fresh(input logic [7:0] c);
        name_state = MS_IDLE;
        if (blank_char(c)) begin
            return;
        end else if (number_char(c)) begin
            add_result(KIND_CHAR, c);
            number_open = 1'b1;
        end else if (operator_char(c)) begin
            close_number();
            add_result(KIND_CHAR, c);
            add_result(KIND_END_TOKEN, 8'd0);
        end else if (c == "s") begin
            name_state = MS_S;
        end else if (c == "c") begin
            name_state = MS_C;
        end else if (c == "t") begin
            name_state = MS_T;
        end else if (c == "l") begin
            name_state = MS_L;
        end
    endtask

    task automatic emit_function(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        close_number();
        add_result(KIND_CHAR, a);
        add_result(KIND_CHAR, b);
        add_result(KIND_CHAR, c);
        add_result(KIND_END_TOKEN, 8'd0);
        name_state = MS_IDLE;
    endtask

    task automatic predict_tokens(input logic req, input logic [7:0] c);
        token_out_t r;
        step_q.delete();
        if (req == REQ_END) begin
            if (name_state == MS_LN) add_result(KIND_END_TOKEN, 8'd0);
            name_state = MS_IDLE;
            close_number();
            add_result(KIND_END_EXPR, 8'd0);
        end else begin
            case (name_state)
                MS_S:  if (c == "i") name_state = MS_SI; else start_fresh(c);
                MS_SI: if (c == "n") emit_function("s", "i", "n"); else start_fresh(c);
                MS_C:  if (c == "o") name_state = MS_CO; else start_fresh(c);
                MS_CO: if (c == "s") emit_function("c", "o", "s"); else start_fresh(c);
                MS_T:  if (c == "a") name_state = MS_TA; else start_fresh(c);
                MS_TA: if (c == "n") emit_function("t", "a", "n"); else start_fresh(c);
                MS_L: begin
                    if (c == "n") begin
                        close_number();
                        add_result(KIND_CHAR, "l");
                        add_result(KIND_CHAR, "n");
                        name_state = MS_LN;
                    end else begin
                        start_fresh(c);
                    end
                end
                MS_LN: begin
                    if (letter_char(c)) begin
                        add_result(KIND_CHAR, c);
                        add_result(KIND_END_TOKEN, 8'd0);
                        name_state = MS_IDLE;
                    end else begin
                        add_result(KIND_END_TOKEN, 8'd0);
                        start_fresh(c);
                    end
                end
                default: start_fresh(c);
            endcase
        end
        foreach (step_q[i]) begin
            r = step_q[i];
            r.last = (i == step_q.size() - 1);
            token_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            token_q.delete();
            name_state  = MS_IDLE;
            number_open = 1'b0;
        end else begin
            // results first: a result can never belong to the transaction taken this edge
            if (m_valid && m_ready) begin
                n_results++;
                if (token_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, got kind=%0d char=%02h last=%0b",
                             $time, m_out_kind, m_out_char, m_run_last);
                end else begin
                    want = token_q.pop_front();
                    if (m_out_kind !== want.kind || m_out_char !== want.chr ||
                        m_run_last !== want.last) begin
                        err_count++;
                        $display("%0t: result mismatch: expected kind=%0d char=%02h last=%0b, got kind=%0d char=%02h last=%0b",
                                 $time, want.kind, want.chr, want.last,
                                 m_out_kind, m_out_char, m_run_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_inputs++;
                predict_tokens(s_req_type, s_ch);
            end
        end
        n_pending <= token_q.size();
    end

endmodule

>>> tb/tb_expression_tokenizer_core.sv
// top of the expression tokenizer testbench: clock, reset, character stimulus
// and the verdict; depends on expression_tokenizer_core and the checker module
module tb_expression_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_CHAR    = 1'b0;
    localparam logic REQ_END     = 1'b1;
    localparam int   HOLD_CYCLES = 80;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [7:0] s_ch       = 8'd0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [1:0] m_out_kind;
    logic [7:0] m_out_char;
    logic       m_run_last;

    int err_count;
    int n_pending;
    int n_inputs;
    int n_results;
    int tx_max_gap   = 11;
    int rx_max_stall = 11;
    int rx_hold      = 0;
    int n_counted    = 0;

    always #6 aclk = ~aclk;

    expression_tokenizer_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last)
    );

    expression_tokenizer_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last),
        .err_count  (err_count),
        .n_pending  (n_pending),
        .n_inputs   (n_inputs),
        .n_results  (n_results)
    );

    // called and returns at a falling edge
    task automatic send_item(input logic req, input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_ch       <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_counted++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_item(REQ_CHAR, t[i]);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (n_pending != 0) @(negedge aclk);
    endtask

    task automatic send_expression();
        string ops;
        string funcs;
        int    k;
        ops   = "+-*/^%()";
        funcs = "sincostan";
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4))
                        send_item(REQ_CHAR, ($urandom_range(0, 5) == 0) ?
                                  8'(".") : 8'("0" + $urandom_range(0, 9)));
                end
                3, 4: send_item(REQ_CHAR, ops[$urandom_range(0, 7)]);
                5: begin
                    k = $urandom_range(0, 2);
                    send_text(funcs.substr(3 * k, 3 * k + 2));
                end
                6: begin
                    send_text("ln");
                    if ($urandom_range(0, 1)) begin
                        k = $urandom_range(0, 51);
                        send_item(REQ_CHAR, (k < 26) ? 8'("A" + k) : 8'("a" + k - 26));
                    end
                end
                7: begin
                    k = $urandom_range(8, 13);
                    send_item(REQ_CHAR, (k == 8) ? 8'd32 : 8'(k));
                end
                8: begin
                    // name prefix that the next token breaks off
                    k = $urandom_range(0, 3);
                    if (k == 3) send_item(REQ_CHAR, "l");
                    else send_text(funcs.substr(3 * k, 3 * k + $urandom_range(0, 1)));
                end
                default: send_item(REQ_CHAR, 8'($urandom_range(0, 255)));
            endcase
        end
        send_item(REQ_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_text("+-*/^%()");
        send_text("9.");
        send_item(REQ_CHAR, 8'hFF);
        send_text("sinlnZln0cx");
        send_item(REQ_END, 8'h00);
        send_text("ln");
        send_item(REQ_END, 8'hFF);
        send_text("ta");
        send_item(REQ_END, 8'h00);

        while (n_counted < 100) send_expression();

        tx_max_gap   = 0;
        rx_max_stall = 0;
        while (n_counted < 150) send_expression();

        rx_hold = HOLD_CYCLES;
        repeat (4) send_expression();
        wait_for_drain();

        while (n_counted < 250) begin
            tx_max_gap   = $urandom_range(0, 11);
            rx_max_stall = $urandom_range(0, 11);
            send_expression();
        end

        wait_for_drain();
        repeat (16) @(negedge aclk);

        $display("covered %0d character and end-mark transactions, %0d token transactions",
                 n_inputs, n_results);
        $display("with random idling, back-to-back traffic and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (err_count == 0 && n_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> expression_tokenizer_core.f
+incdir+rtl/core
rtl/core/etok_pkg.sv
rtl/core/etok_decode.sv
rtl/core/expression_tokenizer_core.sv
tb/expression_tokenizer_checker.sv
tb/tb_expression_tokenizer_core.sv
